// File: rtl/hpc_pkg.sv
// Shared constants, register codes and helper functions of the hierarchical probing colorer.
package hpc_pkg;

  // Field widths.
  localparam int IDX_W       = 24;
  localparam int EXT_W       = 7;
  localparam int DIMS_W      = 3;
  localparam int BL_W        = 3;
  localparam int ROW_W       = 16;
  localparam int COLOR_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Largest extent a used direction may have.
  localparam int EXTENT_MAX  = 64;
  localparam int LIMIT_W     = 11;

  // Reciprocal divide: quotient estimate = (n * floor(2^SHIFT / e)) >> SHIFT.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned RECIP_ONE = 32'd1 << RECIP_SHIFT;
  localparam int RECIP_DEPTH = 1 << EXT_W;
  localparam int PROD_W      = IDX_W + RECIP_W;
  localparam int REM_W       = EXT_W + 1;

  // Partial volume widths.
  localparam int VOL2_W      = 2 * EXT_W;
  localparam int VOL3_W      = 3 * EXT_W;
  localparam int VOL4_W      = 4 * EXT_W;

  // Dimension counts.
  localparam logic [DIMS_W-1:0] DIMS_3D = 3'd3;
  localparam logic [DIMS_W-1:0] DIMS_4D = 3'd4;

  // Largest block_log2 that keeps the color count within 65536.
  localparam logic [BL_W-1:0] BL_MAX_3D = 3'd5;
  localparam logic [BL_W-1:0] BL_MAX_4D = 3'd3;

  // Reset values of the registers.
  localparam logic [EXT_W-1:0] EXT_RESET  = 7'd16;
  localparam logic [BL_W-1:0]  BL_RESET   = 3'd1;
  localparam logic [ROW_W-1:0] ROW_RESET  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTENT_X     = 3'd0,
    CFG_EXTENT_Y     = 3'd1,
    CFG_EXTENT_Z     = 3'd2,
    CFG_EXTENT_T     = 3'd3,
    CFG_DIMS         = 3'd4,
    CFG_BLOCK_LOG2   = 3'd5,
    CFG_HADAMARD_ROW = 3'd6
  } cfg_reg_t;

  // Bit number bl of a coordinate, zero above its width.
  function automatic logic bit_at(input logic [EXT_W-1:0] c, input logic [BL_W-1:0] bl);
    logic [EXT_W-1:0] sh;
    sh = c >> bl;
    return sh[0];
  endfunction

  // Remainder correction of the reciprocal divide.
  function automatic logic rem_over(input logic [REM_W-1:0] r, input logic [EXT_W-1:0] e);
    return r >= {1'b0, e};
  endfunction

endpackage

// File: rtl/hierarchical_probing_colorer_top.sv
// Top level of the hierarchical probing colorer: pipelined site-to-color datapath.
//
// Takes one lexicographic site index per transaction and returns one result per
// transaction: the hierarchical probing color, the Hadamard sign for the configured
// row and an invalid flag. Sustained rate is one site per clock while the output side
// does not stall. The pipeline is an input register, three divide units in series
// (x, y, z), each a reciprocal multiply, a remainder stage and a correction stage,
// then a color stage and the output register. Each stage holds a valid bit and
// advances whenever the stage ahead of it is empty or advancing, so bubbles collapse
// and input keeps flowing while a finished result waits.
// Write configuration only while the pipeline is empty; the extents, dims, block_log2
// and row are read directly by the stages that use them.
module hierarchical_probing_colorer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hpc_pkg::IDX_W-1:0]       in_site_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hpc_pkg::COLOR_W-1:0]     out_color,
  output logic                            out_sign_negative,
  output logic                            out_invalid,
  input  logic                            cfg_we,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hpc_pkg::*;

  localparam int NS = 12;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0]  ext_x_r, ext_y_r, ext_z_r, ext_t_r;
  logic [DIMS_W-1:0] dims_r;
  logic [BL_W-1:0]   bl_r;
  logic [ROW_W-1:0]  row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_x_r <= EXT_RESET;
      ext_y_r <= EXT_RESET;
      ext_z_r <= EXT_RESET;
      ext_t_r <= EXT_RESET;
      dims_r  <= DIMS_4D;
      bl_r    <= BL_RESET;
      row_r   <= ROW_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_EXTENT_X:     ext_x_r <= cfg_wdata[EXT_W-1:0];
        CFG_EXTENT_Y:     ext_y_r <= cfg_wdata[EXT_W-1:0];
        CFG_EXTENT_Z:     ext_z_r <= cfg_wdata[EXT_W-1:0];
        CFG_EXTENT_T:     ext_t_r <= cfg_wdata[EXT_W-1:0];
        CFG_DIMS:         dims_r  <= cfg_wdata[DIMS_W-1:0];
        CFG_BLOCK_LOG2:   bl_r    <= cfg_wdata[BL_W-1:0];
        CFG_HADAMARD_ROW: row_r   <= cfg_wdata[ROW_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Reciprocal table floor(2^24 / e), one entry per extent code. Extent zero
  // maps to the extent-one entry; its volume is zero so the site is flagged.
  // ---------------------------------------------------------------------------
  logic [RECIP_W-1:0] recip_tbl [RECIP_DEPTH];

  for (genvar g = 0; g < RECIP_DEPTH; g++) begin : g_recip
    localparam logic [RECIP_W-1:0] RV = RECIP_W'(RECIP_ONE / ((g == 0) ? 1 : g));
    assign recip_tbl[g] = RV;
  end

  // ---------------------------------------------------------------------------
  // Stage valids and the advance chain. A stage loads when it or any stage
  // ahead of it is empty, or when the output is being taken.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready | ~(&v_r[NS-1:k]);
  end

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  // ---------------------------------------------------------------------------
  // Stage 0: capture the index and the x reciprocal.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]   s0_idx_r;
  logic [RECIP_W-1:0] s0_rcp_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_idx_r <= in_site_index;
      s0_rcp_r <= recip_tbl[ext_x_r];
    end
  end

  // ---------------------------------------------------------------------------
  // x divide. Stage 1 multiplies by the reciprocal; stage 2 forms the remainder
  // of the quotient estimate, which is low by at most one; stage 3 corrects it.
  // The volume product is built alongside: x times y, then z, then t in 4D.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] s1_prod_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [VOL2_W-1:0] s1_vol_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_prod_r <= PROD_W'(s0_idx_r) * PROD_W'(s0_rcp_r);
      s1_idx_r  <= s0_idx_r;
      s1_vol_r  <= VOL2_W'(ext_x_r) * VOL2_W'(ext_y_r);
    end
  end

  logic [IDX_W-1:0]       s2_q_nxt;
  logic [IDX_W+EXT_W-1:0] s2_qe;
  logic [IDX_W-1:0]       s2_diff;
  logic [IDX_W-1:0]       s2_q_r;
  logic [REM_W-1:0]       s2_rem_r;
  logic [IDX_W-1:0]       s2_idx_r;
  logic [VOL3_W-1:0]      s2_vol_r;

  always_comb begin
    s2_q_nxt = s1_prod_r[RECIP_SHIFT +: IDX_W];
    s2_qe    = (IDX_W+EXT_W)'(s2_q_nxt) * (IDX_W+EXT_W)'(ext_x_r);
    s2_diff  = s1_idx_r - s2_qe[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_q_r   <= s2_q_nxt;
      s2_rem_r <= s2_diff[REM_W-1:0];
      s2_idx_r <= s1_idx_r;
      s2_vol_r <= VOL3_W'(s1_vol_r) * VOL3_W'(ext_z_r);
    end
  end

  logic                s3_fix;
  logic [REM_W-1:0]    s3_rem_fix;
  logic [IDX_W-1:0]    s3_n_r;
  logic [EXT_W-1:0]    s3_cx_r;
  logic [IDX_W-1:0]    s3_idx_r;
  logic [VOL4_W-1:0]   s3_vol_r;
  logic [RECIP_W-1:0]  s3_rcp_r;

  always_comb begin
    s3_fix     = rem_over(s2_rem_r, ext_x_r);
    s3_rem_fix = s3_fix ? (s2_rem_r - REM_W'(ext_x_r)) : s2_rem_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_n_r   <= s2_q_r + IDX_W'(s3_fix);
      s3_cx_r  <= s3_rem_fix[EXT_W-1:0];
      s3_idx_r <= s2_idx_r;
      s3_vol_r <= (dims_r == DIMS_4D) ? VOL4_W'(s2_vol_r) * VOL4_W'(ext_t_r)
                                      : VOL4_W'(s2_vol_r);
      s3_rcp_r <= recip_tbl[ext_y_r];
    end
  end

  // ---------------------------------------------------------------------------
  // y divide, stages 4 to 6. The bounds check against the volume rides here.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] s4_prod_r;
  logic [IDX_W-1:0]  s4_n_r;
  logic [EXT_W-1:0]  s4_cx_r;
  logic              s4_beyond_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_prod_r   <= PROD_W'(s3_n_r) * PROD_W'(s3_rcp_r);
      s4_n_r      <= s3_n_r;
      s4_cx_r     <= s3_cx_r;
      s4_beyond_r <= VOL4_W'(s3_idx_r) >= s3_vol_r;
    end
  end

  logic [IDX_W-1:0]       s5_q_nxt;
  logic [IDX_W+EXT_W-1:0] s5_qe;
  logic [IDX_W-1:0]       s5_diff;
  logic [IDX_W-1:0]       s5_q_r;
  logic [REM_W-1:0]       s5_rem_r;
  logic [EXT_W-1:0]       s5_cx_r;
  logic                   s5_beyond_r;

  always_comb begin
    s5_q_nxt = s4_prod_r[RECIP_SHIFT +: IDX_W];
    s5_qe    = (IDX_W+EXT_W)'(s5_q_nxt) * (IDX_W+EXT_W)'(ext_y_r);
    s5_diff  = s4_n_r - s5_qe[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_q_r      <= s5_q_nxt;
      s5_rem_r    <= s5_diff[REM_W-1:0];
      s5_cx_r     <= s4_cx_r;
      s5_beyond_r <= s4_beyond_r;
    end
  end

  logic               s6_fix;
  logic [REM_W-1:0]   s6_rem_fix;
  logic [IDX_W-1:0]   s6_n_r;
  logic [EXT_W-1:0]   s6_cx_r;
  logic [EXT_W-1:0]   s6_cy_r;
  logic               s6_beyond_r;
  logic [RECIP_W-1:0] s6_rcp_r;

  always_comb begin
    s6_fix     = rem_over(s5_rem_r, ext_y_r);
    s6_rem_fix = s6_fix ? (s5_rem_r - REM_W'(ext_y_r)) : s5_rem_r;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_n_r      <= s5_q_r + IDX_W'(s6_fix);
      s6_cy_r     <= s6_rem_fix[EXT_W-1:0];
      s6_cx_r     <= s5_cx_r;
      s6_beyond_r <= s5_beyond_r;
      s6_rcp_r    <= recip_tbl[ext_z_r];
    end
  end

  // ---------------------------------------------------------------------------
  // z divide, stages 7 to 9. Inside the volume the quotient is the t coordinate;
  // for three dimensions it is zero and unused.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0] s7_prod_r;
  logic [IDX_W-1:0]  s7_n_r;
  logic [EXT_W-1:0]  s7_cx_r;
  logic [EXT_W-1:0]  s7_cy_r;
  logic              s7_beyond_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_prod_r   <= PROD_W'(s6_n_r) * PROD_W'(s6_rcp_r);
      s7_n_r      <= s6_n_r;
      s7_cx_r     <= s6_cx_r;
      s7_cy_r     <= s6_cy_r;
      s7_beyond_r <= s6_beyond_r;
    end
  end

  logic [IDX_W-1:0]       s8_q_nxt;
  logic [IDX_W+EXT_W-1:0] s8_qe;
  logic [IDX_W-1:0]       s8_diff;
  logic [IDX_W-1:0]       s8_q_r;
  logic [REM_W-1:0]       s8_rem_r;
  logic [EXT_W-1:0]       s8_cx_r;
  logic [EXT_W-1:0]       s8_cy_r;
  logic                   s8_beyond_r;

  always_comb begin
    s8_q_nxt = s7_prod_r[RECIP_SHIFT +: IDX_W];
    s8_qe    = (IDX_W+EXT_W)'(s8_q_nxt) * (IDX_W+EXT_W)'(ext_z_r);
    s8_diff  = s7_n_r - s8_qe[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_q_r      <= s8_q_nxt;
      s8_rem_r    <= s8_diff[REM_W-1:0];
      s8_cx_r     <= s7_cx_r;
      s8_cy_r     <= s7_cy_r;
      s8_beyond_r <= s7_beyond_r;
    end
  end

  logic             s9_fix;
  logic [REM_W-1:0] s9_rem_fix;
  logic [IDX_W-1:0] s9_quo;
  logic [EXT_W-1:0] s9_cx_r;
  logic [EXT_W-1:0] s9_cy_r;
  logic [EXT_W-1:0] s9_cz_r;
  logic [EXT_W-1:0] s9_ct_r;
  logic             s9_beyond_r;

  always_comb begin
    s9_fix     = rem_over(s8_rem_r, ext_z_r);
    s9_rem_fix = s9_fix ? (s8_rem_r - REM_W'(ext_z_r)) : s8_rem_r;
    s9_quo     = s8_q_r + IDX_W'(s9_fix);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_cz_r     <= s9_rem_fix[EXT_W-1:0];
      s9_ct_r     <= s9_quo[EXT_W-1:0];
      s9_cx_r     <= s8_cx_r;
      s9_cy_r     <= s8_cy_r;
      s9_beyond_r <= s8_beyond_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: configuration checks, block parity and position inside the block.
  // ---------------------------------------------------------------------------
  logic                 four_d;
  logic                 dims_bad;
  logic                 colors_bad;
  logic [EXT_W-1:0]     tile_mask;
  logic [EXT_W-1:0]     pos_mask;
  logic                 tile_bad;
  logic                 big_bad;
  logic                 s10_bad;
  logic                 eo;
  logic [4:0]           sh2;
  logic [4:0]           sh3;
  logic [COLOR_W-1:0]   local_pos;
  logic [COLOR_W-1:0]   s10_color_r;
  logic                 s10_invalid_r;

  always_comb begin
    four_d     = (dims_r == DIMS_4D);
    dims_bad   = (dims_r != DIMS_3D) && (dims_r != DIMS_4D);
    colors_bad = (four_d && (bl_r > BL_MAX_4D)) ||
                 ((dims_r == DIMS_3D) && (bl_r > BL_MAX_3D));
    // Extents must be multiples of twice the block side.
    tile_mask  = EXT_W'((9'd2 << bl_r) - 9'd1);
    pos_mask   = EXT_W'((8'd1 << bl_r) - 8'd1);
    tile_bad   = (|(ext_x_r & tile_mask)) || (|(ext_y_r & tile_mask)) ||
                 (|(ext_z_r & tile_mask)) || (four_d && (|(ext_t_r & tile_mask)));
    big_bad    = (LIMIT_W'(ext_x_r) > LIMIT_W'(EXTENT_MAX)) ||
                 (LIMIT_W'(ext_y_r) > LIMIT_W'(EXTENT_MAX)) ||
                 (LIMIT_W'(ext_z_r) > LIMIT_W'(EXTENT_MAX)) ||
                 (four_d && (LIMIT_W'(ext_t_r) > LIMIT_W'(EXTENT_MAX)));
    s10_bad    = dims_bad || colors_bad || tile_bad || big_bad || s9_beyond_r;

    // Parity of the block coordinate sum is the xor of coordinate bit bl.
    eo = bit_at(s9_cx_r, bl_r) ^ bit_at(s9_cy_r, bl_r) ^ bit_at(s9_cz_r, bl_r) ^
         (four_d & bit_at(s9_ct_r, bl_r));

    sh2 = {1'b0, bl_r, 1'b0};
    sh3 = sh2 + 5'(bl_r);
    local_pos = COLOR_W'(s9_cx_r & pos_mask) |
                (COLOR_W'(s9_cy_r & pos_mask) << bl_r) |
                (COLOR_W'(s9_cz_r & pos_mask) << sh2) |
                (four_d ? (COLOR_W'(s9_ct_r & pos_mask) << sh3) : '0);
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_invalid_r <= s10_bad;
      s10_color_r   <= s10_bad ? '0 : {local_pos[COLOR_W-2:0], eo};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 11: output register with the Hadamard sign. An invalid color is zero,
  // so its sign comes out zero as well.
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] out_color_r;
  logic               out_sign_r;
  logic               out_invalid_r;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      out_color_r   <= s10_color_r;
      out_sign_r    <= ^(s10_color_r & row_r);
      out_invalid_r <= s10_invalid_r;
    end
  end

  assign out_color         = out_color_r;
  assign out_sign_negative = out_sign_r;
  assign out_invalid       = out_invalid_r;

`ifndef NO_ASSERTIONS
  // Input is held off only when every stage is full.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled with an empty stage in the pipeline");

  // A flagged result carries neither a color nor a sign.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_color == '0 && !out_sign_negative))
    else $error("invalid result with nonzero color or sign");

  // The sign matches the parity of color and row.
  a_sign_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sign_negative == ^(out_color & row_r)))
    else $error("Hadamard sign does not match color and row");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

// File: verif/site_color_checker.sv
// Scoreboard for the hierarchical probing colorer: predicts every site's color and checks results.
module site_color_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [hpc_pkg::IDX_W-1:0]           in_site_index,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [hpc_pkg::COLOR_W-1:0]         out_color,
  input  logic                                out_sign_negative,
  input  logic                                out_invalid,
  input  logic                                cfg_we,
  input  logic [hpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                  pending_results,
  output int                                  fail_count,
  output int                                  results_checked,
  output int                                  invalid_results
);
  import hpc_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               sign_negative;
    logic               invalid;
  } site_color_t;

  // Shadow copy of the register file, tracked from the write port.
  logic [EXT_W-1:0]  ext_q [4];
  logic [DIMS_W-1:0] dims_q;
  logic [BL_W-1:0]   bl_q;
  logic [ROW_W-1:0]  row_q;

  site_color_t expected_colors[$];
  site_color_t want;

  function automatic site_color_t predict_site_color(input logic [IDX_W-1:0] site);
    site_color_t      r;
    int unsigned      nd, bl, side2, mask, coord, ext_d, local_pos, bsum;
    longint unsigned  vol, ncolors, rest;
    logic             bad;
    r = '0;
    r.invalid = 1'b1;
    if (dims_q != DIMS_3D && dims_q != DIMS_4D) return r;
    nd = 32'(dims_q);
    bl = 32'(bl_q);
    ncolors = 64'd2 << (nd * bl);
    if (ncolors > 64'd65536) return r;
    side2 = 2 << bl;
    vol = 1;
    bad = 1'b0;
    for (int d = 0; d < nd; d++) begin
      ext_d = 32'(ext_q[d]);
      if (ext_d % side2 != 0 || ext_d > EXTENT_MAX) bad = 1'b1;
      vol = vol * ext_d;
    end
    if (bad || site >= vol) return r;
    // Split the index, x fastest; block coordinates give the parity, the
    // low bits give the position inside the block.
    rest = 64'(site);
    mask = (1 << bl) - 1;
    local_pos = 0;
    bsum = 0;
    for (int d = 0; d < nd; d++) begin
      ext_d = 32'(ext_q[d]);
      coord = 32'(rest % ext_d);
      rest = rest / ext_d;
      bsum += coord >> bl;
      local_pos |= (coord & mask) << (d * bl);
    end
    r.color = COLOR_W'((local_pos << 1) | (bsum & 1));
    r.sign_negative = ^(r.color & row_q);
    r.invalid = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < 4; d++) ext_q[d] = EXT_RESET;
      dims_q = DIMS_4D;
      bl_q = BL_RESET;
      row_q = ROW_RESET;
      expected_colors.delete();
      fail_count = 0;
      results_checked = 0;
      invalid_results = 0;
      pending_results <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result: color %h sign %b invalid %b", $time,
                   out_color, out_sign_negative, out_invalid);
          fail_count++;
        end else begin
          want = expected_colors.pop_front();
          if (out_color !== want.color) begin
            $display("%0t: color mismatch: expected %h, actual %h", $time,
                     want.color, out_color);
            fail_count++;
          end
          if (out_sign_negative !== want.sign_negative) begin
            $display("%0t: sign mismatch: expected %b, actual %b (color %h)", $time,
                     want.sign_negative, out_sign_negative, want.color);
            fail_count++;
          end
          if (out_invalid !== want.invalid) begin
            $display("%0t: invalid flag mismatch: expected %b, actual %b", $time,
                     want.invalid, out_invalid);
            fail_count++;
          end
          results_checked++;
          if (want.invalid) invalid_results++;
        end
      end
      // Predict with the settings in force before any write on this edge.
      if (in_valid && in_ready) expected_colors.push_back(predict_site_color(in_site_index));
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXTENT_X:     ext_q[0] = cfg_wdata[EXT_W-1:0];
          CFG_EXTENT_Y:     ext_q[1] = cfg_wdata[EXT_W-1:0];
          CFG_EXTENT_Z:     ext_q[2] = cfg_wdata[EXT_W-1:0];
          CFG_EXTENT_T:     ext_q[3] = cfg_wdata[EXT_W-1:0];
          CFG_DIMS:         dims_q = cfg_wdata[DIMS_W-1:0];
          CFG_BLOCK_LOG2:   bl_q = cfg_wdata[BL_W-1:0];
          CFG_HADAMARD_ROW: row_q = cfg_wdata[ROW_W-1:0];
          default: ;
        endcase
      end
      pending_results <= expected_colors.size();
    end
  end

endmodule

// File: verif/hierarchical_probing_colorer_top_test.sv
// Stimulus and verdict for the hierarchical probing colorer; checking lives in site_color_checker.
module hierarchical_probing_colorer_top_test;
  import hpc_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int CYCLE_LIMIT     = 200000;
  // Pipeline is 12 deep; extra settling time after the last result.
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_MODES      = 3;
  localparam int PHASES_PER_MODE = 6;
  localparam int SITES_PER_PHASE = 80;

  // Register index past the end of the register list; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED   = 3'd7;
  localparam logic [DIMS_W-1:0]     DIMS_NONE      = 3'd0;
  localparam logic [DIMS_W-1:0]     DIMS_TOO_MANY  = 3'd7;
  localparam logic [CFG_DATA_W-1:0] EXT_DATA_MASK  = 16'h007F;
  localparam logic [CFG_DATA_W-1:0] CODE_DATA_MASK = 16'h0007;

  typedef struct packed {
    logic [3:0][EXT_W-1:0] ext;
    logic [DIMS_W-1:0]     dims;
    logic [BL_W-1:0]       bl;
    logic [ROW_W-1:0]      row;
  } lattice_setting_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [IDX_W-1:0]       in_site_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COLOR_W-1:0]     out_color;
  logic                   out_sign_negative;
  logic                   out_invalid;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int pending_results, fail_count, results_checked, invalid_results;
  int cycle_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int sites_sent = 0;
  int settings_loaded = 0;

  hierarchical_probing_colorer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_site_index    (in_site_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_color        (out_color),
    .out_sign_negative(out_sign_negative),
    .out_invalid      (out_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  site_color_checker color_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_site_index    (in_site_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_color        (out_color),
    .out_sign_negative(out_sign_negative),
    .out_invalid      (out_invalid),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pending_results  (pending_results),
    .fail_count       (fail_count),
    .results_checked  (results_checked),
    .invalid_results  (invalid_results)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: stop a hung run well past the slowest legal finish.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending", $time,
               cycle_count, pending_results);
      $display("** hierarchical_probing_colorer_top: FAILED **");
      $finish;
    end
  end

  // Result side. A hold request drops ready for a long stretch, counted here,
  // so the pipeline fills and in_ready falls while the sender keeps offering.
  // Otherwise ready drops at random, recv_idle times in a hundred.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted < hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic lattice_setting_t make_setting(input int x, input int y, input int z,
                                                    input int t, input int dims, input int bl,
                                                    input int row);
    lattice_setting_t s;
    s.ext[0] = EXT_W'(x);
    s.ext[1] = EXT_W'(y);
    s.ext[2] = EXT_W'(z);
    s.ext[3] = EXT_W'(t);
    s.dims = DIMS_W'(dims);
    s.bl = BL_W'(bl);
    s.row = ROW_W'(row);
    return s;
  endfunction

  // Mostly legal lattices: every used extent a multiple of twice the block
  // side. About one setting in eight gets one register scrambled over its
  // full width to reach the invalid paths.
  function automatic lattice_setting_t random_setting();
    lattice_setting_t s;
    int unsigned side2;
    s.dims = ($urandom_range(0, 1) == 0) ? DIMS_3D : DIMS_4D;
    s.bl = BL_W'($urandom_range(0, (s.dims == DIMS_3D) ? BL_MAX_3D : BL_MAX_4D));
    side2 = 2 << s.bl;
    for (int d = 0; d < 4; d++) s.ext[d] = EXT_W'(side2 * $urandom_range(1, EXTENT_MAX / side2));
    if (s.dims == DIMS_3D) s.ext[3] = EXT_W'($urandom_range(0, 127));
    s.row = ROW_W'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: s.ext[$urandom_range(0, 3)] = EXT_W'($urandom);
        1: s.bl = BL_W'($urandom);
        default: s.dims = DIMS_W'($urandom);
      endcase
    end
    return s;
  endfunction

  // Mostly sites inside the volume, some on its edges, some anywhere in 24 bits.
  function automatic logic [IDX_W-1:0] pick_site(input lattice_setting_t s);
    longint unsigned vol;
    int unsigned     roll;
    vol = 1;
    for (int d = 0; d < ((s.dims == DIMS_3D) ? 3 : 4); d++) vol = vol * s.ext[d];
    roll = $urandom_range(0, 99);
    if (vol == 0 || vol > (64'd1 << IDX_W) || roll >= 90) return IDX_W'($urandom);
    if (roll >= 80) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return IDX_W'(vol - 1);
        2: return IDX_W'(vol);
        default: return IDX_W'(vol + 1);
      endcase
    end
    return IDX_W'($urandom_range(0, 32'(vol - 1)));
  endfunction

  // Each call starts right after a rising edge and returns right after the
  // edge that accepted the transaction; valid stays up between back-to-back sites.
  task automatic send_site(input logic [IDX_W-1:0] site);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_site_index <= site;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sites_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Write every register; unused upper data bits carry noise that must be dropped.
  task automatic load_setting(input lattice_setting_t s);
    for (int d = 0; d < 4; d++)
      write_reg(cfg_reg_t'(CFG_EXTENT_X + d),
                (CFG_DATA_W'($urandom) & ~EXT_DATA_MASK) | CFG_DATA_W'(s.ext[d]));
    write_reg(CFG_DIMS, (CFG_DATA_W'($urandom) & ~CODE_DATA_MASK) | CFG_DATA_W'(s.dims));
    write_reg(CFG_BLOCK_LOG2, (CFG_DATA_W'($urandom) & ~CODE_DATA_MASK) | CFG_DATA_W'(s.bl));
    write_reg(CFG_HADAMARD_ROW, s.row);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Drop valid, let every outstanding result come back, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    lattice_setting_t s;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset lattice 16^4, block side 2, row 0: first two sites, last site, one past
    // the volume and the top of the index range.
    send_site(24'd0);
    send_site(24'd1);
    send_site(24'd65535);
    send_site(24'd65536);
    send_site(24'hFFFFFF);
    wait_drained();

    // A write past the register list must leave the reset lattice in place.
    write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    send_site(24'd4660);
    wait_drained();

    // Largest 3D lattice with the largest block; extent_t is unused and untiled.
    load_setting(make_setting(64, 64, 64, 5, DIMS_3D, 5, 16'hFFFF));
    send_site(24'd0);
    send_site(24'd33);
    send_site(24'd262143);
    send_site(24'd262144);
    wait_drained();

    // Too many colors: 4D with block side 16.
    load_setting(make_setting(32, 32, 32, 32, DIMS_4D, 4, 16'h1234));
    send_site(24'd0);
    wait_drained();

    // Bad dimension counts at both ends of the field.
    load_setting(make_setting(16, 16, 16, 16, DIMS_NONE, 1, 16'h00FF));
    send_site(24'd0);
    wait_drained();
    load_setting(make_setting(16, 16, 16, 16, DIMS_TOO_MANY, 0, 16'h00FF));
    send_site(24'd0);
    wait_drained();

    // Extent not a multiple of twice the block side.
    load_setting(make_setting(6, 4, 4, 4, DIMS_4D, 1, 16'hAAAA));
    send_site(24'd0);
    wait_drained();

    // Tiled but oversized extent.
    load_setting(make_setting(96, 2, 2, 2, DIMS_4D, 0, 16'hAAAA));
    send_site(24'd0);
    wait_drained();

    // Zero extent: empty volume.
    load_setting(make_setting(2, 0, 2, 2, DIMS_4D, 0, 16'hAAAA));
    send_site(24'd0);
    wait_drained();

    // Smallest lattice, 2^4 sites: corners and one past the end.
    load_setting(make_setting(2, 2, 2, 2, DIMS_4D, 0, 16'h5555));
    send_site(24'd0);
    send_site(24'd5);
    send_site(24'd10);
    send_site(24'd15);
    send_site(24'd16);

    // Random part: three idling regimes, each over several lattice settings.
    // One long output hold per regime forces the pipe to back up.
    for (int mode = 0; mode < IDLE_MODES; mode++) begin
      wait_drained();
      send_idle <= (mode == 0) ? 6 : (mode == 1) ? 70 : 0;
      recv_idle <= (mode == 0) ? 70 : (mode == 1) ? 6 : 0;
      for (int phase = 0; phase < PHASES_PER_MODE; phase++) begin
        s = random_setting();
        if (phase != 0) wait_drained();
        load_setting(s);
        if (phase == 1) hold_requests <= hold_requests + 1;
        for (int n = 0; n < SITES_PER_PHASE; n++) send_site(pick_site(s));
      end
    end
    wait_drained();

    $display("Sent %0d sites over %0d lattice settings; %0d results checked, %0d of them invalid.",
             sites_sent, settings_loaded, results_checked, invalid_results);
    $display("Covered 3D and 4D lattices, all block sizes, invalid setups and %0d output holds.",
             holds_granted);
    if (fail_count == 0) begin
      $display("** hierarchical_probing_colorer_top: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** hierarchical_probing_colorer_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/hpc_pkg.sv
rtl/hierarchical_probing_colorer_top.sv
verif/site_color_checker.sv
verif/hierarchical_probing_colorer_top_test.sv
